// File: rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

  localparam int unsigned PATTERN_MAX     = 8;
  localparam int unsigned REPLACEMENT_MAX = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned HEAD_W = $clog2(REPLACEMENT_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(PATTERN_MAX + REPLACEMENT_MAX + 2);
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LENGTH    = 2'd1,
    REG_REPLACEMENT_BYTES = 2'd2,
    REG_REPLACEMENT_LEN   = 2'd3
  } sfr_reg_e;

  // Configuration as seen by the datapath, lengths already saturated
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0]     pattern;
    logic [FILL_W-1:0]               plen;
    logic [REPLACEMENT_MAX-1:0][7:0] repl;
    logic [HEAD_W-1:0]               rlen;
    logic                            plen_wr;
  } sfr_cfg_t;

  // One classified input: head bytes, then window bytes, then an optional newline
  typedef struct packed {
    logic [REPLACEMENT_MAX-1:0][7:0] head;
    logic [HEAD_W-1:0]               head_len;
    logic [PATTERN_MAX-1:0][7:0]     tail;
    logic [FILL_W-1:0]               tail_len;
    logic                            nl;
    logic [CNT_W-1:0]                total_len;
  } sfr_job_t;

endpackage
`default_nettype wire

// File: rtl/stream_find_replace.sv
// Channel   Direction  Handshake               Payload
// text in   input      push / full             in_byte_i, end_of_stream_i
// text out  output     pop / empty             out_byte_o, last_of_run_o
// config    input      psel/penable/pwrite     paddr, pwdata, prdata (64-bit regs at 8*i)
//
// One text byte is taken per cycle while the job queue is not full; the front
// classifies it against the pattern window in that cycle and queues a job of
// 1 to 9 output beats, or none when the byte yields nothing.
// The back drains one beat per cycle while pop is high; a two-entry job queue
// parts the sides. Reset clears lengths, registers and window fill; no
// clearing pass. Either side may stall without losing or repeating beats.
`default_nettype none
module stream_find_replace (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [7:0]                 in_byte_i,
  input  wire logic                       end_of_stream_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [7:0]                 out_byte_o,
  output logic                            last_of_run_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic      [sfr_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  sfr_pkg::sfr_cfg_t cfg;
  sfr_pkg::sfr_job_t job_in, job_out;
  logic job_push, job_pop, job_empty, accept;

  assign accept = push && !full;

  sfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  sfr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

// File: rtl/sfr_regs.sv
`default_nettype none
module sfr_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic      [sfr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output sfr_pkg::sfr_cfg_t               cfg_o
);

  logic [63:0] pattern_q;
  logic [3:0]  plen_q;
  logic [63:0] repl_q;
  logic [3:0]  rlen_q;
  logic        wr;
  logic [sfr_pkg::REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[sfr_pkg::ADDR_W-1:3];

  // Write the addressed register on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
      repl_q    <= '0;
      rlen_q    <= '0;
    end else if (wr) begin
      case (idx)
        sfr_pkg::REG_PATTERN_BYTES:     pattern_q <= pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:    plen_q    <= pwdata[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES: repl_q    <= pwdata;
        sfr_pkg::REG_REPLACEMENT_LEN:   rlen_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES:     prdata = pattern_q;
      sfr_pkg::REG_PATTERN_LENGTH:    prdata = {60'd0, plen_q};
      sfr_pkg::REG_REPLACEMENT_BYTES: prdata = repl_q;
      sfr_pkg::REG_REPLACEMENT_LEN:   prdata = {60'd0, rlen_q};
      default:                        prdata = '0;
    endcase
  end

  // Saturate lengths to the supported maxima
  always_comb begin
    cfg_o.pattern = pattern_q[sfr_pkg::PATTERN_MAX*8-1:0];
    cfg_o.repl    = repl_q[sfr_pkg::REPLACEMENT_MAX*8-1:0];
    if (plen_q > 4'(sfr_pkg::PATTERN_MAX)) begin
      cfg_o.plen = sfr_pkg::FILL_W'(sfr_pkg::PATTERN_MAX);
    end else begin
      cfg_o.plen = sfr_pkg::FILL_W'(plen_q);
    end
    if (rlen_q > 4'(sfr_pkg::REPLACEMENT_MAX)) begin
      cfg_o.rlen = sfr_pkg::HEAD_W'(sfr_pkg::REPLACEMENT_MAX);
    end else begin
      cfg_o.rlen = sfr_pkg::HEAD_W'(rlen_q);
    end
    cfg_o.plen_wr = wr && (idx == sfr_pkg::REG_PATTERN_LENGTH);
  end

endmodule
`default_nettype wire

// File: rtl/sfr_front.sv
`default_nettype none
module sfr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfr_pkg::sfr_cfg_t cfg_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_of_stream_i,
  output logic                   job_push_o,
  output sfr_pkg::sfr_job_t      job_o
);

  logic [sfr_pkg::PATTERN_MAX-1:0][7:0] win_q, win_d, wtmp, shifted, nwin;
  logic [sfr_pkg::FILL_W-1:0] fill_q, fill_d, fill0, f1, fill_pre;
  logic active, is_nl, full_win, hit;

  assign active = cfg_i.plen != '0;
  assign is_nl  = in_byte_i == sfr_pkg::NEWLINE_BYTE;
  assign fill0  = (fill_q >= cfg_i.plen) ? '0 : fill_q;
  assign f1     = fill0 + 1'b1;
  assign full_win = f1 == cfg_i.plen;

  // Place the new byte and compare against the pattern
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < sfr_pkg::PATTERN_MAX; i++) begin
      wtmp[i] = (sfr_pkg::FILL_W'(i) == fill0) ? in_byte_i : win_q[i];
    end
    for (int i = 0; i < sfr_pkg::PATTERN_MAX; i++) begin
      if (sfr_pkg::FILL_W'(i) < cfg_i.plen && wtmp[i] != cfg_i.pattern[i]) begin
        hit = 1'b0;
      end
    end
    for (int i = 0; i < sfr_pkg::PATTERN_MAX - 1; i++) begin
      shifted[i] = wtmp[i+1];
    end
    shifted[sfr_pkg::PATTERN_MAX-1] = wtmp[sfr_pkg::PATTERN_MAX-1];
  end

  // Classify the beat into head bytes, window flush and newline
  always_comb begin
    job_o.head     = cfg_i.repl;
    job_o.head_len = '0;
    nwin           = wtmp;
    fill_pre       = f1;
    if (is_nl) begin
      nwin     = win_q;
      fill_pre = fill0;
    end else if (full_win && hit) begin
      job_o.head_len = cfg_i.rlen;
      fill_pre       = '0;
    end else if (full_win) begin
      job_o.head[0]  = wtmp[0];
      job_o.head_len = sfr_pkg::HEAD_W'(1);
      nwin           = shifted;
      fill_pre       = cfg_i.plen - 1'b1;
    end
    job_o.tail = nwin;
    job_o.nl   = is_nl || end_of_stream_i;
    if (job_o.nl) begin
      job_o.tail_len = fill_pre;
      fill_d         = '0;
    end else begin
      job_o.tail_len = '0;
      fill_d         = fill_pre;
    end
    win_d = nwin;
    job_o.total_len = sfr_pkg::CNT_W'(job_o.head_len) + sfr_pkg::CNT_W'(job_o.tail_len)
                    + sfr_pkg::CNT_W'(job_o.nl);
  end

  assign job_push_o = accept_i && active && (job_o.total_len != '0);

  // Advance the window fill; a new pattern length drops the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_i.plen_wr) begin
      fill_q <= '0;
    end else if (accept_i && active) begin
      fill_q <= fill_d;
    end
  end

  // Window bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && active) begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sfr_fifo.sv
`default_nettype none
module sfr_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sfr_pkg::sfr_job_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output sfr_pkg::sfr_job_t      data_o,
  output logic                   empty_o
);

  sfr_pkg::sfr_job_t mem_q [sfr_pkg::QUEUE_DEPTH];
  logic [sfr_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [sfr_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  function automatic logic [sfr_pkg::QPTR_W-1:0] bump(logic [sfr_pkg::QPTR_W-1:0] p);
    if (p == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= bump(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= bump(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue underflow");

endmodule
`default_nettype wire

// File: rtl/sfr_back.sv
`default_nettype none
module sfr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfr_pkg::sfr_job_t job_i,
  input  wire logic              job_empty_i,
  output logic                   job_pop_o,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o
);

  sfr_pkg::sfr_job_t job_q;
  logic [sfr_pkg::CNT_W-1:0] idx_q;
  logic busy_q, take, fin;

  assign empty         = !busy_q;
  assign last_of_run_o = idx_q == (job_q.total_len - 1'b1);
  assign take          = busy_q && pop;
  assign fin           = take && last_of_run_o;
  assign job_pop_o     = (!busy_q || fin) && !job_empty_i;

  // Select the byte at the current position of the job
  always_comb begin
    out_byte_o = sfr_pkg::NEWLINE_BYTE;
    for (int i = 0; i < sfr_pkg::REPLACEMENT_MAX; i++) begin
      if (sfr_pkg::HEAD_W'(i) < job_q.head_len && idx_q == sfr_pkg::CNT_W'(i)) begin
        out_byte_o = job_q.head[i];
      end
    end
    for (int j = 0; j < sfr_pkg::PATTERN_MAX; j++) begin
      if (sfr_pkg::FILL_W'(j) < job_q.tail_len &&
          idx_q == sfr_pkg::CNT_W'(job_q.head_len) + sfr_pkg::CNT_W'(j)) begin
        out_byte_o = job_q.tail[j];
      end
    end
  end

  // Load the next job, step through its beats, drop it after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (job_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q < job_q.total_len) else $error("beat index past job end");
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> job_q.total_len != '0) else $error("empty job loaded");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !pop |=> busy_q && $stable(idx_q)) else $error("stalled beat moved");

endmodule
`default_nettype wire

// File: bench/tb_stream_find_replace.sv
module tb_stream_find_replace;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int TEXT_TARGET    = 300;
  localparam int PHASE_BYTES    = 36;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_beat_t;

  typedef struct {
    bit                 is_write;
    sfr_pkg::sfr_reg_e  idx;
    logic [63:0]        data;
    logic [7:0]         ch;
    logic               eos;
    int                 n_typed;
    logic [63:0]        typed;
  } script_row_t;

  logic                        clk_i;
  logic                        rst_ni          = 1'b0;
  logic                        push            = 1'b0;
  logic                        full;
  logic [7:0]                  in_byte_i       = 8'h00;
  logic                        end_of_stream_i = 1'b0;
  logic                        empty;
  logic                        pop             = 1'b0;
  logic [7:0]                  out_byte_o;
  logic                        last_of_run_o;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [sfr_pkg::ADDR_W-1:0]  paddr           = '0;
  logic [sfr_pkg::DATA_W-1:0]  pwdata          = '0;
  logic [sfr_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  // Shadow configuration and window
  logic [63:0] cfg_pattern = '0;
  logic [3:0]  cfg_plen    = '0;
  logic [63:0] cfg_repl    = '0;
  logic [3:0]  cfg_rlen    = '0;
  logic [7:0]  win_bytes [sfr_pkg::PATTERN_MAX];
  int unsigned win_fill    = 0;

  text_beat_t  fresh_beats [$];
  text_beat_t  text_due [$];
  text_beat_t  want_beat;
  script_row_t script [$];

  int  gap_pct     = 0;
  int  stall_pct   = 0;
  bit  holdoff_req = 1'b0;
  int  mismatches  = 0;
  int  beats_seen  = 0;
  int  cycle_cnt   = 0;

  stream_find_replace u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at beat %0d: %s", beats_seen, msg);
    mismatches++;
  endtask

  function automatic void emit(input logic [7:0] ch);
    fresh_beats.push_back(text_beat_t'{ch, 1'b0});
  endfunction

  function automatic void flush_window();
    for (int i = 0; i < win_fill; i++) emit(win_bytes[i]);
    win_fill = 0;
  endfunction

  // Work out the beats that one text byte produces
  function automatic void rewrite_byte(input logic [7:0] ch, input logic eos);
    int unsigned plen;
    int unsigned rlen;
    bit          hit;
    fresh_beats.delete();
    plen = (cfg_plen > sfr_pkg::PATTERN_MAX) ? sfr_pkg::PATTERN_MAX : cfg_plen;
    rlen = (cfg_rlen > sfr_pkg::REPLACEMENT_MAX) ? sfr_pkg::REPLACEMENT_MAX : cfg_rlen;
    if (plen == 0) return;
    if (win_fill >= plen) win_fill = 0;
    if (ch == sfr_pkg::NEWLINE_BYTE) begin
      flush_window();
      emit(sfr_pkg::NEWLINE_BYTE);
    end else begin
      win_bytes[win_fill] = ch;
      win_fill++;
      if (win_fill == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (win_bytes[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) emit(cfg_repl[8*i +: 8]);
          win_fill = 0;
        end else begin
          emit(win_bytes[0]);
          for (int i = 1; i < plen; i++) win_bytes[i-1] = win_bytes[i];
          win_fill--;
        end
      end
    end
    if (eos) begin
      flush_window();
      if (ch != sfr_pkg::NEWLINE_BYTE) emit(sfr_pkg::NEWLINE_BYTE);
    end
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size()-1].fin = 1'b1;
  endfunction

  function automatic void add_beat(input logic [7:0] ch, input logic eos, input int n,
                                   input logic [63:0] typed);
    script_row_t row;
    row.is_write = 1'b0;
    row.idx      = sfr_pkg::REG_PATTERN_BYTES;
    row.data     = '0;
    row.ch       = ch;
    row.eos      = eos;
    row.n_typed  = n;
    row.typed    = typed;
    script.push_back(row);
  endfunction

  function automatic void add_write(input sfr_pkg::sfr_reg_e idx, input logic [63:0] data);
    script_row_t row;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    row.ch       = '0;
    row.eos      = 1'b0;
    row.n_typed  = 0;
    row.typed    = '0;
    script.push_back(row);
  endfunction

  // Offer one beat, then queue what it should produce
  task automatic send_byte(input logic [7:0] ch, input logic eos, input int n_typed,
                           input logic [63:0] typed);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    in_byte_i       <= ch;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (full);
    rewrite_byte(ch, eos);
    if (n_typed < 0) begin
      foreach (fresh_beats[i]) text_due.push_back(fresh_beats[i]);
    end else begin
      for (int i = 0; i < n_typed; i++)
        text_due.push_back(text_beat_t'{typed[8*i +: 8], 1'(i == n_typed - 1)});
    end
  endtask

  // Drain everything outstanding, then let the block go quiet
  task automatic settle_idle();
    push <= 1'b0;
    while (text_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input sfr_pkg::sfr_reg_e idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES:     cfg_pattern = data;
      sfr_pkg::REG_PATTERN_LENGTH: begin
        cfg_plen = data[3:0];
        win_fill = 0;
      end
      sfr_pkg::REG_REPLACEMENT_BYTES: cfg_repl = data;
      sfr_pkg::REG_REPLACEMENT_LEN:   cfg_rlen = data[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check each accepted beat against the oldest outstanding one
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (text_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h last %b", out_byte_o, last_of_run_o));
      end else begin
        want_beat = text_due.pop_front();
        if (out_byte_o !== want_beat.ch)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte_o, want_beat.ch));
        if (last_of_run_o !== want_beat.fin)
          report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, want_beat.fin));
      end
      beats_seen++;
    end
  end

  initial begin
    bit          bus_quiet;
    int          counted;
    int          pick;
    int          run;
    int unsigned plen_eff;
    logic [7:0]  alpha [3];
    logic [63:0] pat;
    logic [3:0]  plen_w;
    logic [3:0]  rlen_w;
    logic [8:0]  plan [$];

    bus_quiet = 1'b1;
    counted   = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle after reset, short pattern, extremes, deletion, newline pattern
    add_beat(8'h00, 1'b0, 0, '0);
    add_beat(8'hFF, 1'b1, 0, '0);
    add_write(sfr_pkg::REG_PATTERN_BYTES, 64'h6261);
    add_write(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_write(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
    add_write(sfr_pkg::REG_REPLACEMENT_LEN, 64'd3);
    add_beat(8'h61, 1'b0, 0, '0);
    add_beat(8'h62, 1'b0, 3, 64'h5A5958);
    add_beat(8'h61, 1'b0, 0, '0);
    add_beat(8'h63, 1'b0, 1, 64'h61);
    add_beat(sfr_pkg::NEWLINE_BYTE, 1'b0, 2, 64'h0A63);
    add_beat(8'h61, 1'b1, 2, 64'h0A61);
    add_beat(sfr_pkg::NEWLINE_BYTE, 1'b1, 1, 64'h0A);
    add_beat(8'h61, 1'b0, 0, '0);
    // rewriting the length drops the pending byte
    add_write(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
    add_write(sfr_pkg::REG_REPLACEMENT_LEN, 64'd15);
    add_write(sfr_pkg::REG_PATTERN_BYTES, '1);
    add_write(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 7; i++) add_beat(8'hFF, 1'b0, 0, '0);
    add_beat(8'hFF, 1'b1, -1, '0);
    add_write(sfr_pkg::REG_REPLACEMENT_LEN, 64'd0);
    add_write(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
    add_write(sfr_pkg::REG_PATTERN_BYTES, 64'h00);
    add_beat(8'h00, 1'b0, 0, '0);
    add_beat(8'h7F, 1'b1, 2, 64'h0A7F);
    add_write(sfr_pkg::REG_PATTERN_BYTES, 64'(sfr_pkg::NEWLINE_BYTE));
    add_beat(sfr_pkg::NEWLINE_BYTE, 1'b0, 1, 64'h0A);

    foreach (script[r]) begin
      if (script[r].is_write) begin
        if (!bus_quiet) begin
          settle_idle();
          bus_quiet = 1'b1;
        end
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_byte(script[r].ch, script[r].eos, script[r].n_typed, script[r].typed);
        bus_quiet = 1'b0;
      end
    end

    // Random phases: new settings and idling pattern each time
    for (int p = 0; counted < TEXT_TARGET || p < 6; p++) begin
      settle_idle();
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++)
        pat[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : alpha[$urandom_range(0, 2)];
      pick = $urandom_range(0, 11);
      plen_w = (pick == 0) ? 4'd0 : (pick < 3) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(1, 8));
      rlen_w = 4'($urandom_range(0, 15));
      case (p)
        0: begin plen_w = 4'd8;  rlen_w = 4'd8;  end
        1: begin plen_w = 4'd15; rlen_w = 4'd15; end
        2: begin plen_w = 4'd1;  rlen_w = 4'd0;  end
        3: plen_w = 4'd0;
        4, 5: plen_w = 4'($urandom_range(1, 8));
        default: ;
      endcase
      write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen_w));
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_reg(sfr_pkg::REG_REPLACEMENT_LEN, 64'(rlen_w));

      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase

      // Mostly whole or partial pattern runs, with noise and newlines
      plen_eff = (cfg_plen > sfr_pkg::PATTERN_MAX) ? sfr_pkg::PATTERN_MAX : cfg_plen;
      plan.delete();
      while (plan.size() < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 50 && plen_eff > 0) begin
          run = (pick < 35) ? plen_eff : $urandom_range(1, plen_eff);
          for (int i = 0; i < run; i++) plan.push_back({1'b0, cfg_pattern[8*i +: 8]});
        end else if (pick < 80) begin
          plan.push_back({1'b0, alpha[$urandom_range(0, 2)]});
        end else if (pick < 92) begin
          plan.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else begin
          plan.push_back({1'b0, sfr_pkg::NEWLINE_BYTE});
        end
      end
      foreach (plan[i]) if ($urandom_range(0, 39) == 0) plan[i][8] = 1'b1;

      if (p == 4) holdoff_req = 1'b1;
      foreach (plan[k]) begin
        // hold the sender until every outstanding beat is back
        if (p == 5 && k == PHASE_BYTES / 2) begin
          push <= 1'b0;
          do @(posedge clk_i); while (text_due.size() != 0);
        end
        send_byte(plan[k][7:0], plan[k][8], -1, '0);
        counted++;
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
